// ----- sv/pfc_pkg.sv -----
// ----------------------------------------------------------------------------
// Pixel format converter package
// Shared format codes, register indexes, luma weights and pipeline types.
// ----------------------------------------------------------------------------
package pfc_pkg;

  // Pixel format codes.
  localparam logic [1:0] FMT_RGBA = 2'd0;
  localparam logic [1:0] FMT_BGRA = 2'd1;
  localparam logic [1:0] FMT_RGB  = 2'd2;
  localparam logic [1:0] FMT_GRAY = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_SOURCE_FORMAT = 2'd0;
  localparam logic [1:0] REG_TARGET_FORMAT = 2'd1;
  localparam logic [1:0] REG_CONV_PARAM    = 2'd2;

  // APB geometry: three 32-bit registers at byte addresses 0, 4 and 8.
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // BT.709 luma weights in Q16; they sum to 65536.
  localparam logic [15:0] LUMA_WR = 16'd13933;
  localparam logic [15:0] LUMA_WG = 16'd46871;
  localparam logic [15:0] LUMA_WB = 16'd4732;

  // Datapath widths.
  localparam int unsigned PROD_W = 24;  // 16 x 8 luma product
  localparam int unsigned WSUM_W = 10;  // sum of three 8-bit weights
  localparam int unsigned REM_W  = 18;  // weighted sum, at most 255 * 765
  localparam int unsigned DS_W   = 17;  // divisor shifted up by seven

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [1:0]  source_format;
    logic [1:0]  target_format;
    logic [23:0] conversion_parameter;
  } cfg_t;

  // Word carried through the divider stages.
  typedef struct packed {
    logic [7:0]       o0;
    logic [7:0]       o1;
    logic [7:0]       o2;
    logic [7:0]       o3;
    logic [2:0]       byte_count;
    logic             last;
    logic             gray;
    logic [REM_W-1:0] rem;
    logic [DS_W-1:0]  ds;
    logic [7:0]       quot;
  } pix_t;

endpackage

// ----- sv/pfc_if.sv -----
// ----------------------------------------------------------------------------
// Pixel stream interfaces
// Valid/ready channels for source pixels and converted pixels.
// ----------------------------------------------------------------------------
interface pfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte0;
  logic [7:0] in_byte1;
  logic [7:0] in_byte2;
  logic [7:0] in_byte3;
  logic       last_pixel;

  modport source (output valid, in_byte0, in_byte1, in_byte2, in_byte3, last_pixel,
                  input ready);
  modport sink (input valid, in_byte0, in_byte1, in_byte2, in_byte3, last_pixel,
                output ready);
endinterface

interface pfc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte0;
  logic [7:0] out_byte1;
  logic [7:0] out_byte2;
  logic [7:0] out_byte3;
  logic [2:0] byte_count;
  logic       last_out;

  modport source (output valid, out_byte0, out_byte1, out_byte2, out_byte3, byte_count,
                  last_out, input ready);
  modport sink (input valid, out_byte0, out_byte1, out_byte2, out_byte3, byte_count,
                last_out, output ready);
endinterface

// ----- sv/pfc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Pixel format converter configuration registers
// APB register file holding source format, target format and the parameter.
// ----------------------------------------------------------------------------
module pfc_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pfc_pkg::ADDR_W-1:0] paddr,
  input  logic [pfc_pkg::DATA_W-1:0] pwdata,
  output logic [pfc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output pfc_pkg::cfg_t              cfg
);
  import pfc_pkg::*;

  logic       wr_en;
  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign reg_index = paddr[ADDR_W-1:2];

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_index)
        REG_SOURCE_FORMAT: cfg.source_format        <= pwdata[1:0];
        REG_TARGET_FORMAT: cfg.target_format        <= pwdata[1:0];
        REG_CONV_PARAM:    cfg.conversion_parameter <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (reg_index)
      REG_SOURCE_FORMAT: prdata = {30'd0, cfg.source_format};
      REG_TARGET_FORMAT: prdata = {30'd0, cfg.target_format};
      REG_CONV_PARAM:    prdata = {8'd0, cfg.conversion_parameter};
      default:           prdata = '0;
    endcase
  end

endmodule

// ----- sv/pfc_div_stage.sv -----
// ----------------------------------------------------------------------------
// Pixel format converter divider stage
// One pipeline stage of the restoring divider, two quotient bits per stage.
// ----------------------------------------------------------------------------
module pfc_div_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  output logic          up_ready,
  input  pfc_pkg::pix_t up_data,
  output logic          down_valid,
  input  logic          down_ready,
  output pfc_pkg::pix_t down_data
);
  import pfc_pkg::*;

  pix_t data_next;
  logic ge0;
  logic ge1;
  logic [REM_W-1:0] rem_mid;
  logic [DS_W-1:0]  ds_mid;

  // The stage takes a word when it is empty or its word moves on.
  assign up_ready = !down_valid || down_ready;

  // Two compare-and-subtract steps against a divisor that shifts right.
  always_comb begin
    data_next = up_data;
    ge0       = up_data.rem >= {1'b0, up_data.ds};
    rem_mid   = ge0 ? up_data.rem - {1'b0, up_data.ds} : up_data.rem;
    ds_mid    = up_data.ds >> 1;
    ge1       = rem_mid >= {1'b0, ds_mid};
    data_next.rem  = ge1 ? rem_mid - {1'b0, ds_mid} : rem_mid;
    data_next.ds   = ds_mid >> 1;
    data_next.quot = {up_data.quot[5:0], ge0, ge1};
    // A gray result shows the running quotient; the last stage leaves the final one.
    if (up_data.gray) begin
      data_next.o0 = {up_data.quot[5:0], ge0, ge1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (up_ready) begin
      down_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      down_data <= data_next;
    end
  end

endmodule

// ----- sv/pixel_format_converter.sv -----
// ----------------------------------------------------------------------------
// Pixel format converter
// Converts one pixel per word between RGBA, BGRA, RGB and 8-bit gray.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock unless the output stalls and delivers each
// converted pixel in order, whatever the formats. The pipeline depth is set
// by the gray path: one stage unpacks the pixel, one forms the three weighted
// products, one adds them, and four stages of a restoring divider each find two
// bits of the quotient by the sum of the weights (a zero parameter selects the
// BT.709 weights, whose result is the top byte of the sum). Every stage holds its
// word under back-pressure and takes a new one as soon as it is empty, so bubbles
// close up. Registers are to be written only while no pixel is in flight.
module pixel_format_converter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pfc_pkg::ADDR_W-1:0] paddr,
  input  logic [pfc_pkg::DATA_W-1:0] pwdata,
  output logic [pfc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  pfc_in_if.sink                     pix_in,
  pfc_out_if.source                  pix_out
);
  import pfc_pkg::*;

  localparam int unsigned DIV_STAGES = 4;

  cfg_t cfg;

  pfc_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [7:0]        wr;
  logic [7:0]        wg;
  logic [7:0]        wb;
  logic [WSUM_W-1:0] wsum;
  logic              luma;

  assign wr   = cfg.conversion_parameter[23:16];
  assign wg   = cfg.conversion_parameter[15:8];
  assign wb   = cfg.conversion_parameter[7:0];
  assign wsum = {2'd0, wr} + {2'd0, wg} + {2'd0, wb};
  assign luma = (wsum == '0);

  // Stage one: unpack the source into r, g, b, a and pack the target.
  logic [7:0] u_r, u_g, u_b, u_a;
  logic [7:0] n_o0, n_o1, n_o2, n_o3;
  logic [2:0] n_count;
  logic       n_gray;

  always_comb begin
    u_r = pix_in.in_byte0;
    u_g = pix_in.in_byte1;
    u_b = pix_in.in_byte2;
    u_a = pix_in.in_byte3;
    case (cfg.source_format)
      FMT_RGBA: ;
      FMT_BGRA: begin
        u_r = pix_in.in_byte2;
        u_b = pix_in.in_byte0;
      end
      FMT_RGB: u_a = cfg.conversion_parameter[7:0];
      default: begin
        u_g = pix_in.in_byte0;
        u_b = pix_in.in_byte0;
        u_a = cfg.conversion_parameter[7:0];
      end
    endcase

    case (cfg.target_format)
      FMT_RGB:  n_count = 3'd3;
      FMT_GRAY: n_count = 3'd1;
      default:  n_count = 3'd4;
    endcase

    n_gray = 1'b0;
    n_o0   = '0;
    n_o1   = '0;
    n_o2   = '0;
    n_o3   = '0;
    if (cfg.source_format == cfg.target_format) begin
      // Same format: the bytes that the format uses pass through.
      n_o0 = pix_in.in_byte0;
      if (n_count != 3'd1) begin
        n_o1 = pix_in.in_byte1;
        n_o2 = pix_in.in_byte2;
      end
      if (n_count == 3'd4) begin
        n_o3 = pix_in.in_byte3;
      end
    end else begin
      case (cfg.target_format)
        FMT_RGBA: begin
          n_o0 = u_r;
          n_o1 = u_g;
          n_o2 = u_b;
          n_o3 = u_a;
        end
        FMT_BGRA: begin
          n_o0 = u_b;
          n_o1 = u_g;
          n_o2 = u_r;
          n_o3 = u_a;
        end
        FMT_RGB: begin
          n_o0 = u_r;
          n_o1 = u_g;
          n_o2 = u_b;
        end
        default: n_gray = 1'b1;
      endcase
    end
  end

  logic       s1_valid, s1_ready;
  logic [7:0] s1_o0, s1_o1, s1_o2, s1_o3;
  logic [2:0] s1_count;
  logic       s1_last, s1_gray;
  logic [7:0] s1_r, s1_g, s1_b;

  logic       s2_valid, s2_ready;
  logic [7:0] s2_o0, s2_o1, s2_o2, s2_o3;
  logic [2:0] s2_count;
  logic       s2_last, s2_gray;
  logic [PROD_W-1:0] s2_pr, s2_pg, s2_pb;

  logic       s3_valid, s3_ready;
  pix_t       s3_data;

  assign pix_in.ready = !s1_valid || s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_in.ready) begin
      s1_valid <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_in.ready && pix_in.valid) begin
      s1_o0    <= n_o0;
      s1_o1    <= n_o1;
      s1_o2    <= n_o2;
      s1_o3    <= n_o3;
      s1_count <= n_count;
      s1_last  <= pix_in.last_pixel;
      s1_gray  <= n_gray;
      s1_r     <= u_r;
      s1_g     <= u_g;
      s1_b     <= u_b;
    end
  end

  // Stage two: weighted products, luma or parameter weights.
  logic [PROD_W-1:0] m_pr, m_pg, m_pb;

  always_comb begin
    if (luma) begin
      m_pr = PROD_W'(LUMA_WR) * PROD_W'(s1_r);
      m_pg = PROD_W'(LUMA_WG) * PROD_W'(s1_g);
      m_pb = PROD_W'(LUMA_WB) * PROD_W'(s1_b);
    end else begin
      m_pr = PROD_W'(wr) * PROD_W'(s1_r);
      m_pg = PROD_W'(wg) * PROD_W'(s1_g);
      m_pb = PROD_W'(wb) * PROD_W'(s1_b);
    end
  end

  assign s1_ready = !s2_valid || s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      s2_o0    <= s1_o0;
      s2_o1    <= s1_o1;
      s2_o2    <= s1_o2;
      s2_o3    <= s1_o3;
      s2_count <= s1_count;
      s2_last  <= s1_last;
      s2_gray  <= s1_gray;
      s2_pr    <= m_pr;
      s2_pg    <= m_pg;
      s2_pb    <= m_pb;
    end
  end

  // Stage three: add the products and set up the divider.
  logic [PROD_W-1:0] sum;
  pix_t              d_init;

  always_comb begin
    sum               = s2_pr + s2_pg + s2_pb;
    d_init.o0         = s2_o0;
    d_init.o1         = s2_o1;
    d_init.o2         = s2_o2;
    d_init.o3         = s2_o3;
    d_init.byte_count = s2_count;
    d_init.last       = s2_last;
    d_init.gray       = s2_gray;
    d_init.quot       = '0;
    if (luma) begin
      // Dividing the top byte by one leaves it as the quotient.
      d_init.rem = {{(REM_W-8){1'b0}}, sum[PROD_W-1:PROD_W-8]};
      d_init.ds  = {{(DS_W-8){1'b0}}, 8'd128};
    end else begin
      d_init.rem = sum[REM_W-1:0];
      d_init.ds  = {wsum, 7'd0};
    end
  end

  assign s2_ready = !s3_valid || s3_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s2_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s2_valid) begin
      s3_data <= d_init;
    end
  end

  // Stages four to seven: the divider chain.
  logic [DIV_STAGES:0] dv_valid;
  logic [DIV_STAGES:0] dv_ready;
  pix_t                dv_data [DIV_STAGES+1];

  assign dv_valid[0] = s3_valid;
  assign dv_data[0]  = s3_data;
  assign s3_ready    = dv_ready[0];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    pfc_div_stage u_div (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (dv_valid[k]),
      .up_ready   (dv_ready[k]),
      .up_data    (dv_data[k]),
      .down_valid (dv_valid[k+1]),
      .down_ready (dv_ready[k+1]),
      .down_data  (dv_data[k+1])
    );
  end

  // Converted pixel straight from the last stage register.
  assign dv_ready[DIV_STAGES] = pix_out.ready;
  assign pix_out.valid        = dv_valid[DIV_STAGES];
  assign pix_out.out_byte0    = dv_data[DIV_STAGES].o0;
  assign pix_out.out_byte1    = dv_data[DIV_STAGES].o1;
  assign pix_out.out_byte2    = dv_data[DIV_STAGES].o2;
  assign pix_out.out_byte3    = dv_data[DIV_STAGES].o3;
  assign pix_out.byte_count   = dv_data[DIV_STAGES].byte_count;
  assign pix_out.last_out     = dv_data[DIV_STAGES].last;

endmodule
